### sv/rsti_pkg.sv
// shared types, codes and constants of the radix string to integer parser
`default_nettype none

package rsti_pkg;

    // width of the reported value; results wrap to this many bits
    localparam int VALUE_WIDTH = 64;

    // fixed field widths
    localparam int ACC_W   = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int PROD_W  = ACC_W + RADIX_W;

    localparam logic [ACC_W-1:0] VALUE_MASK = {ACC_W{1'b1}} >> (ACC_W - VALUE_WIDTH);

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] UPPER_BASE = 8'h37;  // 'A' - 10
    localparam logic [CHAR_W-1:0] LOWER_BASE = 8'h57;  // 'a' - 10

    // radix bounds and reset values
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [ACC_W-1:0]   LIMIT_RESET = {ACC_W{1'b1}};

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIX  = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_SIGNED = 2'd2
    } cfg_idx_t;

    // running outcome of the string being parsed
    typedef enum logic [1:0] {
        OC_NONE     = 2'd0,
        OC_OK       = 2'd1,
        OC_OVERFLOW = 2'd2,
        OC_INVALID  = 2'd3
    } outcome_t;

    // reported status
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [ACC_W-1:0]   limit;
        logic               signed_mode;
    } cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        outcome_t         outcome;
        logic             negative;
        logic             at_start;
    } parse_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              no_char;
        logic              is_last;
    } item_t;

    typedef struct packed {
        logic [ACC_W-1:0] value_bits;
        status_t          status;
    } result_t;

    localparam parse_t PARSE_CLEAR = '{acc: '0, outcome: OC_NONE, negative: 1'b0,
                                       at_start: 1'b1};

endpackage : rsti_pkg

`default_nettype wire

### sv/rsti_step.sv
// one parse step: digit decode, multiply-add with limit check, and the final result
`default_nettype none

module rsti_step (
    input  wire rsti_pkg::cfg_t    cfg,
    input  wire rsti_pkg::parse_t  cur,
    input  wire rsti_pkg::item_t   item,
    output rsti_pkg::parse_t       nxt,
    output rsti_pkg::result_t      res
);
    import rsti_pkg::*;

    // digit value of a byte; the flag is low for a non-digit
    function automatic logic [RADIX_W:0] digit_of(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] v;
        logic              ok;
        begin
            ok = 1'b1;
            if (ch >= CHAR_0 && ch <= CHAR_9)
                v = ch - CHAR_0;
            else if (ch >= CHAR_UA && ch <= CHAR_UZ)
                v = ch - UPPER_BASE;
            else if (ch >= CHAR_LA && ch <= CHAR_LZ)
                v = ch - LOWER_BASE;
            else
            begin
                v  = '0;
                ok = 1'b0;
            end
            digit_of = {ok, v[RADIX_W-1:0]};
        end
    endfunction

    logic [RADIX_W-1:0] base;
    logic [RADIX_W:0]   dec;
    logic [RADIX_W-1:0] digit;
    logic               digit_ok;
    logic [PROD_W-1:0]  prod;
    logic               over;
    logic               prod_eq;
    logic               is_minus;
    logic               take;
    parse_t             upd;
    logic               at_limit;
    logic [ACC_W-1:0]   neg_acc;

    // base clamped to the usable range
    always_comb
    begin
        if (cfg.radix < RADIX_MIN)
            base = RADIX_MIN;
        else if (cfg.radix > RADIX_MAX)
            base = RADIX_MAX;
        else
            base = cfg.radix;
    end

    assign dec      = digit_of(item.character);
    assign digit    = dec[RADIX_W-1:0];
    assign digit_ok = dec[RADIX_W] && (digit < base);

    // acc * base + digit is formed at full width and compared with the limit
    assign prod    = {{RADIX_W{1'b0}}, cur.acc} * {{ACC_W{1'b0}}, base}
                     + {{ACC_W{1'b0}}, digit};
    assign over    = prod > {{RADIX_W{1'b0}}, cfg.limit};
    assign prod_eq = prod == {{RADIX_W{1'b0}}, cfg.limit};

    assign is_minus = cfg.signed_mode && cur.at_start && (item.character == CHAR_MINUS);

    // state after taking the character
    always_comb
    begin
        upd  = cur;
        take = 1'b0;
        if (!item.no_char)
        begin
            upd.at_start = 1'b0;
            if (is_minus)
                upd.negative = 1'b1;
            else if (cur.outcome == OC_INVALID)
                upd.outcome = OC_INVALID;
            else if (!digit_ok)
                upd.outcome = OC_INVALID;
            else if (cur.outcome == OC_OVERFLOW)
                upd.outcome = OC_OVERFLOW;
            else if (over)
                upd.outcome = OC_OVERFLOW;
            else
            begin
                upd.acc     = prod[ACC_W-1:0];
                upd.outcome = OC_OK;
                take        = 1'b1;
            end
        end
    end

    assign at_limit = take ? prod_eq : (cur.acc == cfg.limit);
    assign neg_acc  = ~upd.acc + {{(ACC_W-1){1'b0}}, 1'b1};

    // final value and status, used only on the last word
    always_comb
    begin
        res.value_bits = '0;
        res.status     = ST_OK;
        case (upd.outcome)
            OC_NONE, OC_INVALID:
                res.status = ST_INVALID;
            OC_OVERFLOW:
                res.status = ST_OVERFLOW;
            OC_OK:
            begin
                if (cfg.signed_mode && upd.negative)
                    res.value_bits = neg_acc & VALUE_MASK;
                else if (cfg.signed_mode && at_limit)
                    res.status = ST_OVERFLOW;
                else
                    res.value_bits = upd.acc & VALUE_MASK;
            end
            default:
                res.status = ST_INVALID;
        endcase
    end

    // the last word clears the parse for the next string
    assign nxt = item.is_last ? PARSE_CLEAR : upd;

endmodule : rsti_step

`default_nettype wire

### sv/radix_string_to_integer.sv
// radix string to integer parser, top level
//
// Input words carry one byte of the string each: s_tdata holds the byte,
// s_tuser marks a word with no byte (used to end an empty string) and
// s_tlast marks the final word of a string. Only the final word produces a
// result word on the master side: m_tdata is the value, two's complement in
// signed mode and zero on error, m_tuser the status (ok, invalid, overflow).
// Base, magnitude limit and signed mode are set through the cfg write port; the
// user must write them only while no string is in progress (not enforced here).
//
// Throughput is one word per cycle unless a last word waits for a full output
// register. A taken word sits in the input register while one multiply-add by
// the base, the limit compare and the result selection run combinationally
// into the state and output registers; m_tvalid is the output register's
// valid. The accumulator feedback through that multiply-add sets the clock rate.
//
// Reset restores base 10, limit all ones and unsigned mode, and clears the
// parse. While the receiver stalls, one result waits in the output register
// and words that are not last keep flowing; a further last word waits in
// the input register until the result is taken.
`default_nettype none

module radix_string_to_integer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // character[7:0]
    input  wire logic        s_tuser,   // no_char
    input  wire logic        s_tlast,
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // value_bits[63:0]
    output logic [1:0]       m_tuser    // status[1:0]
);
    import rsti_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    parse_t  state_reg;
    parse_t  state_next;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    logic    out_free;
    logic    in_go;
    logic    out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix       <= RADIX_RESET;
            cfg_reg.limit       <= LIMIT_RESET;
            cfg_reg.signed_mode <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RADIX:  cfg_reg.radix       <= cfg_data[RADIX_W-1:0];
                CFG_LIMIT:  cfg_reg.limit       <= cfg_data;
                CFG_SIGNED: cfg_reg.signed_mode <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // handshake: the input register moves on unless a last word meets a full output
    assign out_free = !out_valid_reg || m_tready;
    assign in_go    = in_valid_reg && (!in_item_reg.is_last || out_free);
    assign out_load = in_go && in_item_reg.is_last;
    assign s_tready = !in_valid_reg || in_go;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.character <= s_tdata;
            in_item_reg.no_char   <= s_tuser;
            in_item_reg.is_last   <= s_tlast;
        end
    end

    rsti_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PARSE_CLEAR;
        else if (in_go)
            state_reg <= state_next;
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= out_load;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.value_bits;
    assign m_tuser  = out_res_reg.status;

    // an error result never carries a value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("error result with non-zero value");

    // a last word leaves a cleared parse behind
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> state_reg.at_start && (state_reg.outcome == OC_NONE)
                     && !state_reg.negative && (state_reg.acc == '0))
        else $error("parse state not cleared after last word");

    // a held input word is never overwritten
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_go |-> !s_tready)
        else $error("input register overwritten");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

endmodule : radix_string_to_integer

`default_nettype wire
